// ===== rtl/core/dps_pkg.sv =====
// shared types and constants for the dynamic priority scheduler
// no dependencies; used by dps_cell and dynamic_priority_scheduler_unit
package dps_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int VAL_W         = 16;
    localparam int OUT_SLOT_W    = 3;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 56;

    localparam logic signed [VAL_W-1:0] PRIO_MIN = 16'sh8000;
    localparam logic [VAL_W-1:0]        CNT_MAX  = 16'hFFFF;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK
    } t_op;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] prio;
        logic [VAL_W-1:0]        rem;
        logic [VAL_W-1:0]        cnt;
    } t_entry;

    typedef struct packed {
        logic                    found;
        logic                    finished;
        logic signed [VAL_W-1:0] prio;
        logic [VAL_W-1:0]        rem;
        logic [VAL_W-1:0]        cnt;
    } t_sel;

endpackage

// ===== rtl/core/dps_cell.sv =====
// one position of the ordered task chain: holds one entry and its slot id
// depends on dps_pkg; instantiated in a row by dynamic_priority_scheduler_unit
module dps_cell #(
    parameter int SLOT_W = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dps_pkg::t_op         i_op,
    input  dps_pkg::t_entry      i_load,
    input  logic [SLOT_W-1:0]    i_load_slot,
    input  dps_pkg::t_entry      i_left,
    input  logic [SLOT_W-1:0]    i_left_slot,
    input  logic                 i_left_ge,
    input  dps_pkg::t_entry      i_right,
    input  logic [SLOT_W-1:0]    i_right_slot,
    input  logic                 i_right_moving,
    input  dps_pkg::t_sel        i_sel,
    input  logic [SLOT_W-1:0]    i_sel_slot,
    output dps_pkg::t_entry      o_entry,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_ge,
    output logic                 o_moving,
    output dps_pkg::t_sel        o_sel,
    output logic [SLOT_W-1:0]    o_sel_slot
);

    dps_pkg::t_entry     r_entry, n_entry;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    dps_pkg::t_sel       own_upd;
    logic                hit;
    logic                gt;

    assign o_entry = r_entry;
    assign o_slot  = r_slot;
    assign o_ge    = r_entry.valid && (r_entry.prio >= i_load.prio);

    always_comb begin
        own_upd.found    = 1'b1;
        own_upd.finished = (r_entry.rem == dps_pkg::VAL_W'(1));
        own_upd.rem      = r_entry.rem - dps_pkg::VAL_W'(1);
        own_upd.prio     = (r_entry.prio == dps_pkg::PRIO_MIN) ? r_entry.prio
                                                               : r_entry.prio - 16'sd1;
        own_upd.cnt      = (r_entry.cnt == dps_pkg::CNT_MAX) ? r_entry.cnt
                                                             : r_entry.cnt + dps_pkg::VAL_W'(1);
    end

    assign hit      = !i_sel.found && r_entry.valid && (r_entry.rem != '0);
    assign gt       = r_entry.valid && (r_entry.prio > i_sel.prio);
    assign o_moving = hit || (i_sel.found && gt);

    always_comb begin
        if (i_sel.found) begin
            o_sel      = i_sel;
            o_sel_slot = i_sel_slot;
        end else if (hit) begin
            o_sel      = own_upd;
            o_sel_slot = r_slot;
        end else begin
            o_sel      = i_sel;
            o_sel_slot = i_sel_slot;
        end
    end

    always_comb begin
        n_entry = r_entry;
        n_slot  = r_slot;
        case (i_op)
            dps_pkg::OP_LOAD: begin
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_entry = i_load;
                        n_slot  = i_load_slot;
                    end else begin
                        n_entry = i_left;
                        n_slot  = i_left_slot;
                    end
                end
            end
            dps_pkg::OP_TICK: begin
                if (o_moving) begin
                    if (i_right_moving) begin
                        n_entry = i_right;
                        n_slot  = i_right_slot;
                    end else begin
                        n_entry.valid = 1'b1;
                        n_entry.prio  = o_sel.prio;
                        n_entry.rem   = o_sel.rem;
                        n_entry.cnt   = o_sel.cnt;
                        n_slot        = o_sel_slot;
                    end
                end else if (i_sel.found && r_entry.valid && (r_entry.cnt != '0)) begin
                    n_entry.cnt = own_upd.cnt;
                end
            end
            default: begin
                n_entry = r_entry;
                n_slot  = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.prio <= n_entry.prio;
        r_entry.rem  <= n_entry.rem;
        r_entry.cnt  <= n_entry.cnt;
        r_slot       <= n_slot;
    end

endmodule

// ===== rtl/core/dynamic_priority_scheduler_unit.sv =====
// Dynamic priority scheduler: keeps up to MAX_TASKS tasks in a row of cells ordered by
// descending priority. A load (s_axis_tuser = 0) inserts a task behind all entries of
// equal or higher priority and gives no result; a load into a full row is dropped. A tick
// (s_axis_tuser = 1) runs the first entry with time left, ages it and moves it back behind
// entries of strictly higher priority, returning one transaction. Each transaction is first
// captured in the input register; the whole cell row then selects, shifts and updates
// together. A tick waits in the capture register while an earlier result is still
// held on the output, so with a stalled output loads keep passing and the input stalls
// once one more tick has been captured.
// depends on dps_pkg and dps_cell
module dynamic_priority_scheduler_unit #(
    parameter int MAX_TASKS = dps_pkg::MAX_TASKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // task_priority[15:0], task_run_time[31:16]
    input  logic [dps_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot[2:0], remaining[18:3], new_priority[34:19], cpu_count[50:35], finished[51], zero
    output logic [dps_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // idle
    output logic                            m_axis_tuser
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    logic                            r_busy;
    logic                            r_mode;
    logic signed [dps_pkg::VAL_W-1:0] r_prio;
    logic [dps_pkg::VAL_W-1:0]       r_run;
    logic [CNT_W-1:0]                r_count;
    logic                            r_m_valid;
    logic [dps_pkg::M_TDATA_W-1:0]   r_m_data;
    logic                            r_m_idle;

    logic                            exec;
    logic                            full;
    dps_pkg::t_op                    op;
    dps_pkg::t_entry                 load_entry;
    logic [SLOT_W-1:0]               load_slot;
    logic [SLOT_W+2:0]               slot_ext;

    dps_pkg::t_entry                 c_entry  [MAX_TASKS];
    logic [SLOT_W-1:0]               c_slot   [MAX_TASKS];
    logic                            c_ge     [MAX_TASKS];
    logic                            c_moving [MAX_TASKS];
    dps_pkg::t_sel                   c_sel    [MAX_TASKS+1];
    logic [SLOT_W-1:0]               c_sel_slot [MAX_TASKS+1];

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_idle;

    assign full = (r_count == CNT_W'(MAX_TASKS));
    assign exec = r_busy && ((r_mode == dps_pkg::MODE_LOAD) || !r_m_valid || m_axis_tready);

    always_comb begin
        op = dps_pkg::OP_NONE;
        if (exec) begin
            if (r_mode == dps_pkg::MODE_TICK) begin
                op = dps_pkg::OP_TICK;
            end else if (!full) begin
                op = dps_pkg::OP_LOAD;
            end
        end
    end

    assign load_entry.valid = 1'b1;
    assign load_entry.prio  = r_prio;
    assign load_entry.rem   = r_run;
    assign load_entry.cnt   = '0;
    assign load_slot        = r_count[SLOT_W-1:0];

    assign c_sel[0]      = '0;
    assign c_sel_slot[0] = '0;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        dps_pkg::t_entry   left_entry, right_entry;
        logic [SLOT_W-1:0] left_slot, right_slot;
        logic              left_ge, right_moving;

        if (k == 0) begin : g_first
            assign left_entry = '0;
            assign left_slot  = '0;
            assign left_ge    = 1'b1;
        end else begin : g_mid_l
            assign left_entry = c_entry[k-1];
            assign left_slot  = c_slot[k-1];
            assign left_ge    = c_ge[k-1];
        end

        if (k == MAX_TASKS - 1) begin : g_last
            assign right_entry  = '0;
            assign right_slot   = '0;
            assign right_moving = 1'b0;
        end else begin : g_mid_r
            assign right_entry  = c_entry[k+1];
            assign right_slot   = c_slot[k+1];
            assign right_moving = c_moving[k+1];
        end

        dps_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_op           (op),
            .i_load         (load_entry),
            .i_load_slot    (load_slot),
            .i_left         (left_entry),
            .i_left_slot    (left_slot),
            .i_left_ge      (left_ge),
            .i_right        (right_entry),
            .i_right_slot   (right_slot),
            .i_right_moving (right_moving),
            .i_sel          (c_sel[k]),
            .i_sel_slot     (c_sel_slot[k]),
            .o_entry        (c_entry[k]),
            .o_slot         (c_slot[k]),
            .o_ge           (c_ge[k]),
            .o_moving       (c_moving[k]),
            .o_sel          (c_sel[k+1]),
            .o_sel_slot     (c_sel_slot[k+1])
        );
    end

    assign slot_ext = {3'b000, c_sel_slot[MAX_TASKS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (op == dps_pkg::OP_LOAD) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (op == dps_pkg::OP_TICK) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end

        if (s_axis_tvalid && s_axis_tready) begin
            r_mode <= s_axis_tuser;
            r_prio <= s_axis_tdata[15:0];
            r_run  <= s_axis_tdata[31:16];
        end

        if (op == dps_pkg::OP_TICK) begin
            if (c_sel[MAX_TASKS].found) begin
                r_m_data <= {4'b0000,
                             c_sel[MAX_TASKS].finished,
                             c_sel[MAX_TASKS].cnt,
                             c_sel[MAX_TASKS].prio,
                             c_sel[MAX_TASKS].rem,
                             slot_ext[dps_pkg::OUT_SLOT_W-1:0]};
                r_m_idle <= 1'b0;
            end else begin
                r_m_data <= '0;
                r_m_idle <= 1'b1;
            end
        end
    end

endmodule

// ===== bench/dynamic_priority_scheduler_unit_tb.sv =====
// self-checking bench for dynamic_priority_scheduler_unit: loads and ticks go in on the
// input stream, every tick result is checked against an in-bench scheduler predictor
// depends on dps_pkg and the scheduler rtl
`timescale 1ns / 1ps

module dynamic_priority_scheduler_unit_tb;

    localparam int NUM_SLOTS   = dps_pkg::MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic                             idle;
        logic                             finished;
        logic [dps_pkg::VAL_W-1:0]        cpu_count;
        logic signed [dps_pkg::VAL_W-1:0] new_prio;
        logic [dps_pkg::VAL_W-1:0]        remaining;
        logic [dps_pkg::OUT_SLOT_W-1:0]   slot;
    } t_sched_result;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [dps_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [dps_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tuser;

    // scheduler shadow state
    logic signed [dps_pkg::VAL_W-1:0] tsk_prio [NUM_SLOTS];
    logic [dps_pkg::VAL_W-1:0]        tsk_rem  [NUM_SLOTS];
    logic [dps_pkg::VAL_W-1:0]        tsk_cnt  [NUM_SLOTS];
    int                               run_order [NUM_SLOTS];
    int                               slots_used = 0;

    t_sched_result tick_results_q[$];

    int src_gap_pct   = 0;
    int snk_stall_pct = 0;
    int mismatches    = 0;
    int loads_sent    = 0;
    int ticks_sent    = 0;
    int idle_seen     = 0;
    int finished_seen = 0;
    int cycle_cnt     = 0;

    dynamic_priority_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void sched_load(input logic signed [dps_pkg::VAL_W-1:0] prio,
                                       input logic [dps_pkg::VAL_W-1:0] run);
        int pos;
        pos = 0;
        if (slots_used >= NUM_SLOTS)
            return;
        while (pos < slots_used && tsk_prio[run_order[pos]] >= prio)
            pos++;
        for (int k = slots_used; k > pos; k--)
            run_order[k] = run_order[k-1];
        run_order[pos] = slots_used;
        tsk_prio[slots_used] = prio;
        tsk_rem[slots_used]  = run;
        tsk_cnt[slots_used]  = '0;
        slots_used++;
    endfunction

    function automatic t_sched_result sched_tick();
        t_sched_result res;
        int sel_pos;
        int new_pos;
        int sel;
        int t;
        res = '0;
        sel_pos = 0;
        while (sel_pos < slots_used && tsk_rem[run_order[sel_pos]] == '0)
            sel_pos++;
        if (sel_pos >= slots_used) begin
            res.idle = 1'b1;
            return res;
        end
        sel = run_order[sel_pos];
        tsk_rem[sel] = tsk_rem[sel] - 1'b1;
        if (tsk_cnt[sel] != dps_pkg::CNT_MAX)
            tsk_cnt[sel] = tsk_cnt[sel] + 1'b1;
        if (tsk_prio[sel] != dps_pkg::PRIO_MIN)
            tsk_prio[sel] = tsk_prio[sel] - 16'sd1;
        // move back behind later entries of strictly higher priority
        new_pos = sel_pos;
        while (new_pos + 1 < slots_used && tsk_prio[run_order[new_pos+1]] > tsk_prio[sel]) begin
            run_order[new_pos] = run_order[new_pos+1];
            new_pos++;
        end
        run_order[new_pos] = sel;
        // entries behind it that have already run age by one
        for (int k = new_pos + 1; k < slots_used; k++) begin
            t = run_order[k];
            if (tsk_cnt[t] != '0 && tsk_cnt[t] != dps_pkg::CNT_MAX)
                tsk_cnt[t] = tsk_cnt[t] + 1'b1;
        end
        res.slot      = sel[dps_pkg::OUT_SLOT_W-1:0];
        res.remaining = tsk_rem[sel];
        res.new_prio  = tsk_prio[sel];
        res.cpu_count = tsk_cnt[sel];
        res.finished  = (tsk_rem[sel] == '0);
        return res;
    endfunction

    function automatic int pending_work();
        int sum;
        sum = 0;
        for (int k = 0; k < slots_used; k++)
            sum += tsk_rem[k];
        return sum;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_cnt, what, got, want);
        mismatches++;
    endtask

    task automatic set_traffic(input int gap_pct, input int stall_pct);
        src_gap_pct   = gap_pct;
        snk_stall_pct = stall_pct;
    endtask

    task automatic send_item(input logic mode, input logic signed [dps_pkg::VAL_W-1:0] prio,
                             input logic [dps_pkg::VAL_W-1:0] run);
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {run, prio};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (mode == dps_pkg::MODE_LOAD) begin
            sched_load(prio, run);
            loads_sent++;
        end else begin
            tick_results_q.push_back(sched_tick());
            ticks_sent++;
        end
    endtask

    task automatic send_tick();
        send_item(dps_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_empty_tick();
        set_traffic(0, 0);
        send_tick();
    endtask

    task automatic test_directed_load_tick();
        set_traffic(0, 0);
        send_item(dps_pkg::MODE_LOAD, 16'sh7FFF, 16'd0);
        send_item(dps_pkg::MODE_LOAD, dps_pkg::PRIO_MIN, 16'd2);
        send_item(dps_pkg::MODE_LOAD, 16'sd7, 16'd1);
        send_item(dps_pkg::MODE_LOAD, 16'sd7, 16'd2);
        // equal priorities, floor at the low end, then idle with entries loaded
        repeat (6) send_tick();
    endtask

    task automatic test_random_traffic();
        logic signed [dps_pkg::VAL_W-1:0] prio;
        logic [dps_pkg::VAL_W-1:0]        run;
        int                               gaps [4]   = '{0, 72, 0, 13};
        int                               stalls [4] = '{0, 0, 72, 13};
        for (int p = 0; p < 4; p++) begin
            set_traffic(gaps[p], stalls[p]);
            repeat (250) begin
                // leave one slot for the full-table test
                if (slots_used < NUM_SLOTS - 1 &&
                    (pending_work() == 0 || $urandom_range(99) < 2)) begin
                    case ($urandom_range(3))
                        0, 1:    prio = 16'($urandom_range(8)) - 16'd4;
                        2:       prio = 16'($urandom);
                        default: prio = $urandom_range(1)
                                        ? 16'sh7FFF - 16'($urandom_range(2))
                                        : dps_pkg::PRIO_MIN + 16'($urandom_range(2));
                    endcase
                    run = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(600, 1));
                    send_item(dps_pkg::MODE_LOAD, prio, run);
                end else begin
                    send_tick();
                end
            end
        end
    endtask

    task automatic test_full_table();
        set_traffic(13, 13);
        while (slots_used < NUM_SLOTS)
            send_item(dps_pkg::MODE_LOAD, 16'($urandom), 16'($urandom));
        repeat (3) send_item(dps_pkg::MODE_LOAD, 16'($urandom), 16'($urandom));
        repeat (2) send_tick();
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tick_results_q.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(m_axis_tdata), 64'd0);
            end else begin
                want = tick_results_q.pop_front();
                if (m_axis_tdata[2:0] != want.slot)
                    report_mismatch("slot", 64'(m_axis_tdata[2:0]), 64'(want.slot));
                if (m_axis_tdata[18:3] != want.remaining)
                    report_mismatch("remaining", 64'(m_axis_tdata[18:3]), 64'(want.remaining));
                if (m_axis_tdata[34:19] != want.new_prio)
                    report_mismatch("new_priority", 64'(m_axis_tdata[34:19]),
                                    64'(want.new_prio));
                if (m_axis_tdata[50:35] != want.cpu_count)
                    report_mismatch("cpu_count", 64'(m_axis_tdata[50:35]), 64'(want.cpu_count));
                if (m_axis_tdata[51] != want.finished)
                    report_mismatch("finished", 64'(m_axis_tdata[51]), 64'(want.finished));
                if (m_axis_tdata[dps_pkg::M_TDATA_W-1:52] != '0)
                    report_mismatch("padding", 64'(m_axis_tdata[dps_pkg::M_TDATA_W-1:52]),
                                    64'd0);
                if (m_axis_tuser != want.idle)
                    report_mismatch("idle", 64'(m_axis_tuser), 64'(want.idle));
                if (want.idle)
                    idle_seen++;
                if (want.finished)
                    finished_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_tick();
        test_directed_load_tick();
        test_random_traffic();
        test_full_table();

        s_axis_tvalid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("ran %0d loads and %0d ticks over %0d cycles with mixed source and sink stalls",
                 loads_sent, ticks_sent, cycle_cnt);
        $display("saw %0d finishing ticks and %0d idle reports, %0d mismatches",
                 finished_seen, idle_seen, mismatches);
        if (mismatches == 0 && tick_results_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
